[sv/dts_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// dts_pkg
// Shared types and constants for the delayed tone scheduler: request and
// result payloads, opcodes, and controller/datapath handshake structs.
// ---------------------------------------------------------------------------
package dts_pkg;

	localparam int unsigned SLOT_COUNT = 8;
	localparam int unsigned SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int unsigned REM_W      = 26;
	localparam int unsigned US_PER_MS  = 1000;

	typedef enum logic [1:0] {
		OP_QUEUE   = 2'd0,
		OP_ADVANCE = 2'd1,
		OP_CLEAR   = 2'd2,
		OP_UNUSED  = 2'd3
	} opcode_t;

	typedef enum logic {
		CMD_PLAY = 1'b0,
		CMD_STOP = 1'b1
	} command_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [2:0]  tone_waveform;
		logic [15:0] tone_frequency;
		logic [15:0] tone_duration;
		logic [9:0]  tone_volume;
		logic [15:0] tone_attack;
		logic [15:0] tone_release;
		logic [15:0] start_delay;
		logic [31:0] elapsed_us;
	} item_t;

	typedef struct packed {
		logic        command;
		logic [2:0]  out_waveform;
		logic [15:0] out_frequency;
		logic [15:0] out_duration;
		logic [9:0]  out_volume;
		logic [15:0] out_attack;
		logic [15:0] out_release;
		logic        last_of_run;
	} result_t;

	// tone payload as kept in a slot
	typedef struct packed {
		logic [2:0]  waveform;
		logic [15:0] frequency;
		logic [15:0] duration;
		logic [9:0]  volume;
		logic [15:0] attack;
		logic [15:0] fade_ms;
	} tone_t;

	typedef struct packed {
		logic load;   // request accepted this cycle
		logic scan;   // process the slot under the scan index
		logic flush;  // emit the held result as last of the run
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_last;  // scan index sits on the final slot
	} dp_status_t;

endpackage

`default_nettype wire

[sv/delayed_tone_scheduler_top.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// delayed_tone_scheduler_top
// One-shot tone slot array: queues delayed tones, fires them as time
// advances and emits play or stop-all commands.
//
//   channel   handshake                 payload
//   request   start / busy              item   (item_t)
//   result    result_strobe (1 cycle)   result (result_t)
//   config    cfg_we                    cfg_wdata (audio enable)
//
// Queue, clear and unused requests leave busy low; the result, if any,
// shows in the cycle after acceptance.
// Advance requests raise busy: one slot of the array is examined per
// cycle, then comes a flush state. A firing slot's result is held
// until the next firing slot or the flush state and shows the cycle after.
// Reset frees all slots and sets audio enable to one.
// The receiver cannot stall; each result is valid for exactly one cycle.
// ---------------------------------------------------------------------------
module delayed_tone_scheduler_top
	import dts_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	output logic       busy,
	input  wire item_t item,
	input  wire logic  cfg_we,
	input  wire logic  cfg_wdata,
	output logic       result_strobe,
	output result_t    result
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	dts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (item.opcode),
		.status (status),
		.busy   (busy),
		.cmd    (cmd)
	);

	dts_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.item          (item),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.status        (status),
		.result        (result),
		.result_strobe (result_strobe)
	);

endmodule

`default_nettype wire

[sv/dts_ctrl.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// dts_ctrl
// Controller for the tone scheduler: accepts requests and sequences the
// slot scan for advance requests.
// ---------------------------------------------------------------------------
module dts_ctrl
	import dts_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [1:0] opcode,
	input  wire dp_status_t status,
	output logic            busy,
	output ctrl_cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_SCAN  = 3'b010,
		S_FLUSH = 3'b100
	} state_t;

	state_t state_q, state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd       = '0;
		cmd.load  = start && (state_q == S_IDLE);
		cmd.scan  = (state_q == S_SCAN);
		cmd.flush = (state_q == S_FLUSH);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start && opcode == OP_ADVANCE) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (status.scan_last) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_flush_returns: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FLUSH |=> state_q == S_IDLE)
		else $error("flush did not return to idle");

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && status.scan_last) |=> state_q == S_FLUSH)
		else $error("scan did not end on the final slot");

endmodule

`default_nettype wire

[sv/dts_datapath.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// dts_datapath
// Slot storage, enable register, scan index, held result and the result
// register of the tone scheduler.
// ---------------------------------------------------------------------------
module dts_datapath
	import dts_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire ctrl_cmd_t cmd,
	input  wire item_t     item,
	input  wire logic      cfg_we,
	input  wire logic      cfg_wdata,
	output dp_status_t     status,
	output result_t        result,
	output logic           result_strobe
);

	localparam logic [SLOT_IDX_W-1:0] LAST_IDX = SLOT_IDX_W'(SLOT_COUNT - 1);

	logic                  enable_q;
	logic [SLOT_COUNT-1:0] active_q;
	logic [REM_W-1:0]      rem_q  [SLOT_COUNT];
	tone_t                 tone_q [SLOT_COUNT];
	logic [SLOT_IDX_W-1:0] idx_q;
	logic [31:0]           elapsed_q;
	tone_t                 hold_q;
	logic                  hold_valid_q;
	logic                  strobe_q;
	result_t               result_q;

	tone_t                 in_tone;
	logic                  any_free;
	logic [SLOT_IDX_W-1:0] free_idx;
	logic [REM_W-1:0]      rem_init;
	logic                  store;
	logic                  cur_active;
	logic                  cur_due;
	logic                  fire;
	logic                  emit;
	result_t               emit_res;

	assign in_tone = '{waveform:   item.tone_waveform,
	                   frequency:  item.tone_frequency,
	                   duration:   item.tone_duration,
	                   volume:     item.tone_volume,
	                   attack:     item.tone_attack,
	                   fade_ms:    item.tone_release};

	assign rem_init = REM_W'(32'(item.start_delay) * 32'(US_PER_MS));

	// lowest free slot
	always_comb begin
		any_free = 1'b0;
		free_idx = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				any_free = 1'b1;
				free_idx = SLOT_IDX_W'(i);
			end
		end
	end

	assign store = cmd.load && item.opcode == OP_QUEUE && enable_q
	               && item.start_delay != '0 && any_free;

	assign cur_active = active_q[idx_q];
	assign cur_due    = 32'(rem_q[idx_q]) <= elapsed_q;
	assign fire       = cmd.scan && cur_active && cur_due;

	assign status.scan_last = (idx_q == LAST_IDX);

	function automatic result_t tone_result(tone_t t, logic last);
		result_t r;
		r.command       = CMD_PLAY;
		r.out_waveform  = t.waveform;
		r.out_frequency = t.frequency;
		r.out_duration  = t.duration;
		r.out_volume    = t.volume;
		r.out_attack    = t.attack;
		r.out_release   = t.fade_ms;
		r.last_of_run   = last;
		return r;
	endfunction

	always_comb begin
		emit     = 1'b0;
		emit_res = tone_result(hold_q, 1'b1);
		priority if (cmd.load) begin
			if (enable_q && item.opcode == OP_QUEUE && item.start_delay == '0) begin
				emit     = 1'b1;
				emit_res = tone_result(in_tone, 1'b1);
			end else if (enable_q && item.opcode == OP_CLEAR) begin
				emit             = 1'b1;
				emit_res         = '0;
				emit_res.command = CMD_STOP;
				emit_res.last_of_run = 1'b1;
			end
		end else if (fire) begin
			// a later firing slot releases the held one as not last
			emit     = enable_q && hold_valid_q;
			emit_res = tone_result(hold_q, 1'b0);
		end else if (cmd.flush) begin
			emit     = hold_valid_q;
			emit_res = tone_result(hold_q, 1'b1);
		end else begin
			emit     = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q     <= 1'b1;
			active_q     <= '0;
			idx_q        <= '0;
			hold_valid_q <= 1'b0;
			strobe_q     <= 1'b0;
		end else begin
			strobe_q <= emit;
			if (cfg_we) begin
				enable_q <= cfg_wdata;
			end
			if (cmd.load) begin
				idx_q <= '0;
				if (item.opcode == OP_CLEAR) begin
					active_q <= '0;
				end else if (store) begin
					active_q[free_idx] <= 1'b1;
				end
			end else if (cmd.scan) begin
				if (!status.scan_last) begin
					idx_q <= idx_q + SLOT_IDX_W'(1);
				end
				if (fire) begin
					active_q[idx_q] <= 1'b0;
					hold_valid_q    <= enable_q;
				end
			end else if (cmd.flush) begin
				hold_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			elapsed_q <= item.elapsed_us;
		end
		if (store) begin
			rem_q[free_idx]  <= rem_init;
			tone_q[free_idx] <= in_tone;
		end
		if (fire) begin
			hold_q <= tone_q[idx_q];
		end else if (cmd.scan && cur_active) begin
			rem_q[idx_q] <= rem_q[idx_q] - elapsed_q[REM_W-1:0];
		end
		if (emit) begin
			result_q <= emit_res;
		end
	end

	assign result        = result_q;
	assign result_strobe = strobe_q;

	a_stop_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && result_q.command == CMD_STOP) |-> result_q.last_of_run)
		else $error("stop-all result not marked last");

	a_flush_drains: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> !hold_valid_q)
		else $error("held result survived the flush");

endmodule

`default_nettype wire
